@@ hdl/oas_pkg.sv @@
// Shared types, codes and constants for the obstacle avoidance sequencer.
`timescale 1ns / 1ps
`default_nettype none

package oas_pkg;

    localparam logic [15:0] ECHO_TIMEOUT_US = 16'd30000;
    localparam logic [9:0]  NO_ECHO_CM      = 10'd999;

    // floor(us * 17 / 1000) is exact as (us * DIST_MULT) >> DIST_SHIFT for 15-bit us.
    localparam logic [19:0] DIST_MULT  = 20'd570426;
    localparam int          DIST_SHIFT = 25;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ECHO = 1'b1;

    localparam logic [1:0] REG_FORWARD_DUTY = 2'd0;
    localparam logic [1:0] REG_TURN_DUTY    = 2'd1;
    localparam logic [1:0] REG_OBSTACLE_CM  = 2'd2;

    typedef enum logic [2:0] {
        MODE_STOP  = 3'd0,
        MODE_FWD   = 3'd1,
        MODE_LEFT  = 3'd3,
        MODE_RIGHT = 3'd4,
        MODE_BACK  = 3'd5
    } drive_mode_t;

    localparam logic [2:0] ACT_SCAN    = 3'd0;
    localparam logic [2:0] ACT_STOPPED = 3'd2;

    localparam logic [1:0] DIR_OFF  = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BACK = 2'd2;

    typedef struct packed {
        logic [9:0] distance;
        logic       op;
    } event_t;

    typedef struct packed {
        logic       we;
        logic [1:0] index;
        logic [9:0] data;
    } cfg_write_t;

    typedef struct packed {
        logic [2:0] action;
        logic [9:0] distance_cm;
        logic       measure_request;
        logic [7:0] right_duty;
        logic [7:0] left_duty;
        logic [1:0] right_direction;
        logic [1:0] left_direction;
        logic [7:0] servo_angle;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/oas_in_stage.sv @@
// Input register stage: holds one word and its echo time converted to centimetres.
`timescale 1ns / 1ps
`default_nettype none

module oas_in_stage
    import oas_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic        s_op,
    input  wire logic [14:0] s_echo_us,
    input  wire logic        take,
    output logic             ev_valid,
    output event_t           ev
);

    logic        valid_reg;
    logic        valid_next;
    event_t      ev_reg;
    logic [34:0] product;
    logic [9:0]  echo_cm;

    assign product = {20'd0, s_echo_us} * {15'd0, DIST_MULT};

    always_comb begin
        if (s_echo_us == 15'd0 || {1'b0, s_echo_us} > ECHO_TIMEOUT_US) begin
            echo_cm = NO_ECHO_CM;
        end else begin
            echo_cm = product[DIST_SHIFT +: 10];
        end
    end

    assign s_tready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_tvalid && s_tready) begin
            ev_reg.op       <= s_op;
            ev_reg.distance <= echo_cm;
        end
    end

    assign ev_valid = valid_reg;
    assign ev       = ev_reg;

endmodule

`default_nettype wire

@@ hdl/oas_core.sv @@
// Sequencer state, configuration registers and the result register.
`timescale 1ns / 1ps
`default_nettype none

module oas_core
    import oas_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cfg_write_t cfg,
    input  wire logic       fire,
    input  wire event_t     ev,
    input  wire logic       m_tready,
    output logic            m_tvalid,
    output result_t         result
);

    typedef enum logic [3:0] {
        PH_FRONT_WAIT   = 4'd0,
        PH_FRONT_MEAS   = 4'd1,
        PH_STOP_WAIT    = 4'd2,
        PH_SWEEP_LEFT   = 4'd3,
        PH_LEFT_WAIT    = 4'd4,
        PH_LEFT_MEAS    = 4'd5,
        PH_SWEEP_RIGHT  = 4'd6,
        PH_RIGHT_WAIT   = 4'd7,
        PH_RIGHT_MEAS   = 4'd8,
        PH_SWEEP_CENTER = 4'd9,
        PH_CENTER_WAIT  = 4'd10,
        PH_BACK         = 4'd11,
        PH_BACK_STOP    = 4'd12,
        PH_SPIN         = 4'd13,
        PH_TURN         = 4'd14,
        PH_PAUSE        = 4'd15
    } phase_t;

    logic [7:0]  forward_duty_reg;
    logic [7:0]  turn_duty_reg;
    logic [9:0]  obstacle_cm_reg;

    phase_t      phase_reg, phase_next;
    logic [9:0]  wait_reg, wait_next;
    logic [7:0]  servo_reg, servo_next;
    logic [9:0]  lclr_reg, lclr_next;
    logic [9:0]  rclr_reg, rclr_next;
    logic [9:0]  dist_reg, dist_next;
    drive_mode_t mode_reg, mode_next;
    logic [7:0]  duty_reg, duty_next;
    logic        m_valid_reg, m_valid_next;
    result_t     result_reg, result_next;
    logic        measuring;
    logic        measuring_next;
    logic        scanning_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            forward_duty_reg <= 8'd180;
            turn_duty_reg    <= 8'd200;
            obstacle_cm_reg  <= 10'd20;
        end else if (cfg.we) begin
            case (cfg.index)
                REG_FORWARD_DUTY: forward_duty_reg <= cfg.data[7:0];
                REG_TURN_DUTY:    turn_duty_reg    <= cfg.data[7:0];
                REG_OBSTACLE_CM:  obstacle_cm_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    assign measuring = (phase_reg == PH_FRONT_MEAS) || (phase_reg == PH_LEFT_MEAS)
                    || (phase_reg == PH_RIGHT_MEAS);

    always_comb begin
        phase_next = phase_reg;
        wait_next  = wait_reg;
        servo_next = servo_reg;
        lclr_next  = lclr_reg;
        rclr_next  = rclr_reg;
        dist_next  = dist_reg;
        mode_next  = mode_reg;
        duty_next  = duty_reg;
        if (ev.op == OP_TICK) begin
            if (!measuring) begin
                if (wait_reg <= 10'd1) begin
                    wait_next = 10'd0;
                    case (phase_reg)
                        PH_FRONT_WAIT: begin
                            phase_next = PH_FRONT_MEAS;
                        end
                        PH_STOP_WAIT: begin
                            servo_next = 8'd90;
                            phase_next = PH_SWEEP_LEFT;
                            wait_next  = 10'd25;
                        end
                        PH_SWEEP_LEFT: begin
                            if (servo_reg >= 8'd150) begin
                                phase_next = PH_LEFT_WAIT;
                                wait_next  = 10'd300;
                            end else begin
                                servo_next = servo_reg + 8'd5;
                                wait_next  = 10'd25;
                            end
                        end
                        PH_LEFT_WAIT: begin
                            phase_next = PH_LEFT_MEAS;
                        end
                        PH_SWEEP_RIGHT: begin
                            if (servo_reg <= 8'd30) begin
                                phase_next = PH_RIGHT_WAIT;
                                wait_next  = 10'd300;
                            end else begin
                                servo_next = servo_reg - 8'd5;
                                wait_next  = 10'd25;
                            end
                        end
                        PH_RIGHT_WAIT: begin
                            phase_next = PH_RIGHT_MEAS;
                        end
                        PH_SWEEP_CENTER: begin
                            if (servo_reg >= 8'd90) begin
                                phase_next = PH_CENTER_WAIT;
                                wait_next  = 10'd200;
                            end else begin
                                servo_next = servo_reg + 8'd5;
                                wait_next  = 10'd25;
                            end
                        end
                        PH_CENTER_WAIT: begin
                            if (lclr_reg < obstacle_cm_reg && rclr_reg < obstacle_cm_reg) begin
                                mode_next  = MODE_BACK;
                                duty_next  = forward_duty_reg;
                                phase_next = PH_BACK;
                            end else if (lclr_reg > rclr_reg) begin
                                mode_next  = MODE_LEFT;
                                duty_next  = turn_duty_reg;
                                phase_next = PH_TURN;
                            end else begin
                                mode_next  = MODE_RIGHT;
                                duty_next  = turn_duty_reg;
                                phase_next = PH_TURN;
                            end
                            wait_next = 10'd700;
                        end
                        PH_BACK: begin
                            mode_next  = MODE_STOP;
                            duty_next  = 8'd0;
                            phase_next = PH_BACK_STOP;
                            wait_next  = 10'd300;
                        end
                        PH_BACK_STOP: begin
                            mode_next  = MODE_RIGHT;
                            duty_next  = turn_duty_reg;
                            phase_next = PH_SPIN;
                            wait_next  = 10'd900;
                        end
                        PH_SPIN, PH_TURN: begin
                            mode_next  = MODE_STOP;
                            duty_next  = 8'd0;
                            phase_next = PH_PAUSE;
                            wait_next  = 10'd100;
                        end
                        PH_PAUSE: begin
                            servo_next = 8'd90;
                            phase_next = PH_FRONT_WAIT;
                            wait_next  = 10'd250;
                        end
                        default: ;
                    endcase
                end else begin
                    wait_next = wait_reg - 10'd1;
                end
            end
        end else if (measuring) begin
            dist_next = ev.distance;
            case (phase_reg)
                PH_FRONT_MEAS: begin
                    if (ev.distance > obstacle_cm_reg) begin
                        mode_next  = MODE_FWD;
                        duty_next  = forward_duty_reg;
                        phase_next = PH_PAUSE;
                        wait_next  = 10'd100;
                    end else begin
                        mode_next  = MODE_STOP;
                        duty_next  = 8'd0;
                        phase_next = PH_STOP_WAIT;
                        wait_next  = 10'd400;
                    end
                end
                PH_LEFT_MEAS: begin
                    lclr_next  = ev.distance;
                    servo_next = 8'd150;
                    phase_next = PH_SWEEP_RIGHT;
                    wait_next  = 10'd25;
                end
                default: begin
                    rclr_next  = ev.distance;
                    servo_next = 8'd30;
                    phase_next = PH_SWEEP_CENTER;
                    wait_next  = 10'd25;
                end
            endcase
        end
    end

    assign measuring_next = (phase_next == PH_FRONT_MEAS) || (phase_next == PH_LEFT_MEAS)
                         || (phase_next == PH_RIGHT_MEAS);
    assign scanning_next  = (phase_next <= PH_CENTER_WAIT) && (phase_next != PH_STOP_WAIT);

    always_comb begin
        result_next                 = '0;
        result_next.servo_angle     = servo_next;
        result_next.left_duty       = duty_next;
        result_next.right_duty      = duty_next;
        result_next.measure_request = measuring_next;
        result_next.distance_cm     = dist_next;
        case (mode_next)
            MODE_FWD: begin
                result_next.left_direction  = DIR_FWD;
                result_next.right_direction = DIR_FWD;
            end
            MODE_BACK: begin
                result_next.left_direction  = DIR_BACK;
                result_next.right_direction = DIR_BACK;
            end
            MODE_LEFT: begin
                result_next.left_direction  = DIR_FWD;
                result_next.right_direction = DIR_BACK;
            end
            MODE_RIGHT: begin
                result_next.left_direction  = DIR_BACK;
                result_next.right_direction = DIR_FWD;
            end
            default: begin
                result_next.left_direction  = DIR_OFF;
                result_next.right_direction = DIR_OFF;
            end
        endcase
        if (mode_next != MODE_STOP) begin
            result_next.action = mode_next;
        end else begin
            result_next.action = scanning_next ? ACT_SCAN : ACT_STOPPED;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_FRONT_WAIT;
            wait_reg    <= 10'd250;
            servo_reg   <= 8'd90;
            lclr_reg    <= 10'd0;
            rclr_reg    <= 10'd0;
            dist_reg    <= 10'd0;
            mode_reg    <= MODE_STOP;
            duty_reg    <= 8'd0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (fire) begin
                phase_reg <= phase_next;
                wait_reg  <= wait_next;
                servo_reg <= servo_next;
                lclr_reg  <= lclr_next;
                rclr_reg  <= rclr_next;
                dist_reg  <= dist_next;
                mode_reg  <= mode_next;
                duty_reg  <= duty_next;
            end
        end
        if (fire) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign result   = result_reg;

endmodule

`default_nettype wire

@@ hdl/obstacle_avoidance_sequencer.sv @@
// Top level of the obstacle avoidance sequencer: handshake and stage wiring.
//
//   Channel  Handshake          Payload
//   input    s_tvalid/s_tready  s_tuser: operation; s_tdata: echo_us
//   result   m_tvalid/m_tready  m_tdata: one result word per input word
//   config   cfg_we             cfg_index, cfg_wdata
//
// A word is accepted every cycle while s_tready is high; it passes from the input register
// through the state update into the result register, from which its result is presented.
// Reset is synchronous and active low and returns the sequencer to the front wait.
// When the result register is held by a low m_tready, the input register still
// takes one more word if it is empty, after which s_tready falls until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module obstacle_avoidance_sequencer
    import oas_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [14:0] echo_us, [15] zero
    input  wire logic        s_tuser,   // [0] operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [7:0] servo_angle, [9:8] left_direction,
                                        // [11:10] right_direction, [19:12] left_duty,
                                        // [27:20] right_duty, [28] measure_request,
                                        // [38:29] distance_cm, [41:39] action, [47:42] zero
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [9:0]  cfg_wdata
);

    logic       out_free;
    logic       ev_valid;
    logic       fire;
    event_t     ev;
    cfg_write_t cfg;
    result_t    result;

    assign out_free = !m_tvalid || m_tready;
    assign fire     = ev_valid && out_free;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_wdata;

    oas_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_op      (s_tuser),
        .s_echo_us (s_tdata[14:0]),
        .take      (out_free),
        .ev_valid  (ev_valid),
        .ev        (ev)
    );

    oas_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .fire     (fire),
        .ev       (ev),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .result   (result)
    );

    assign m_tdata = {6'd0, result};

endmodule

`default_nettype wire

@@ tb/oas_result_checker.sv @@
// Checker for the obstacle avoidance sequencer: predicts each result word and compares it.
`timescale 1ns / 1ps

module oas_result_checker
    import oas_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [15:0] s_tdata,   // [14:0] echo_us, [15] zero
    input  wire logic        s_tuser,   // [0] operation
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata,   // result_t in [41:0], zero above
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [9:0]  cfg_wdata,
    output int               failures,
    output int               pending
);

    typedef enum logic [4:0] {
        PH_FRONT_WAIT,
        PH_FRONT_MEAS,
        PH_STOP_WAIT,
        PH_SWEEP_LEFT,
        PH_LEFT_WAIT,
        PH_LEFT_MEAS,
        PH_SWEEP_RIGHT,
        PH_RIGHT_WAIT,
        PH_RIGHT_MEAS,
        PH_SWEEP_CENTRE,
        PH_CENTRE_WAIT,
        PH_BACK,
        PH_BACK_STOP,
        PH_SPIN,
        PH_TURN,
        PH_PAUSE
    } seq_phase_t;

    logic [7:0]  fwd_duty;
    logic [7:0]  spin_duty;
    logic [9:0]  obstacle_cm;
    seq_phase_t  phase;
    int          ms_left;
    logic [7:0]  servo;
    logic [9:0]  left_cm;
    logic [9:0]  right_cm;
    logic [9:0]  last_cm;
    drive_mode_t motion;
    logic [7:0]  motion_duty;
    result_t     commands_due[$];
    result_t     want;
    result_t     got;
    int          fail_count;
    int          word_no;

    function automatic void drive(drive_mode_t m, logic [7:0] d);
        motion = m;
        motion_duty = (m == MODE_STOP) ? 8'd0 : d;
    endfunction

    function automatic void enter(seq_phase_t p, int ms);
        phase = p;
        ms_left = ms;
    endfunction

    function automatic void sweep(seq_phase_t settle, bit upward, logic [7:0] stop_deg,
                                  int settle_ms);
        if (upward ? (servo >= stop_deg) : (servo <= stop_deg)) begin
            enter(settle, settle_ms);
        end else begin
            servo = upward ? servo + 8'd5 : servo - 8'd5;
            ms_left = 25;
        end
    endfunction

    function automatic bit measuring();
        return phase inside {PH_FRONT_MEAS, PH_LEFT_MEAS, PH_RIGHT_MEAS};
    endfunction

    function automatic result_t step_sequencer(logic op, logic [14:0] us);
        result_t r;
        int      cm;
        if (op == OP_TICK) begin
            if (!measuring()) begin
                if (ms_left <= 1) begin
                    ms_left = 0;
                    case (phase)
                        PH_FRONT_WAIT: enter(PH_FRONT_MEAS, 0);
                        PH_STOP_WAIT: begin
                            servo = 8'd90;
                            enter(PH_SWEEP_LEFT, 25);
                        end
                        PH_SWEEP_LEFT: sweep(PH_LEFT_WAIT, 1'b1, 8'd150, 300);
                        PH_LEFT_WAIT: enter(PH_LEFT_MEAS, 0);
                        PH_SWEEP_RIGHT: sweep(PH_RIGHT_WAIT, 1'b0, 8'd30, 300);
                        PH_RIGHT_WAIT: enter(PH_RIGHT_MEAS, 0);
                        PH_SWEEP_CENTRE: sweep(PH_CENTRE_WAIT, 1'b1, 8'd90, 200);
                        PH_CENTRE_WAIT: begin
                            if (left_cm < obstacle_cm && right_cm < obstacle_cm) begin
                                drive(MODE_BACK, fwd_duty);
                                enter(PH_BACK, 700);
                            end else if (left_cm > right_cm) begin
                                drive(MODE_LEFT, spin_duty);
                                enter(PH_TURN, 700);
                            end else begin
                                drive(MODE_RIGHT, spin_duty);
                                enter(PH_TURN, 700);
                            end
                        end
                        PH_BACK: begin
                            drive(MODE_STOP, 8'd0);
                            enter(PH_BACK_STOP, 300);
                        end
                        PH_BACK_STOP: begin
                            drive(MODE_RIGHT, spin_duty);
                            enter(PH_SPIN, 900);
                        end
                        PH_SPIN, PH_TURN: begin
                            drive(MODE_STOP, 8'd0);
                            enter(PH_PAUSE, 100);
                        end
                        PH_PAUSE: begin
                            servo = 8'd90;
                            enter(PH_FRONT_WAIT, 250);
                        end
                        default: ;
                    endcase
                end else begin
                    ms_left--;
                end
            end
        end else if (measuring()) begin
            if (us == 0 || us > ECHO_TIMEOUT_US) cm = NO_ECHO_CM;
            else cm = int'(us) * 17 / 1000;
            last_cm = cm[9:0];
            case (phase)
                PH_FRONT_MEAS: begin
                    if (last_cm > obstacle_cm) begin
                        drive(MODE_FWD, fwd_duty);
                        enter(PH_PAUSE, 100);
                    end else begin
                        drive(MODE_STOP, 8'd0);
                        enter(PH_STOP_WAIT, 400);
                    end
                end
                PH_LEFT_MEAS: begin
                    left_cm = last_cm;
                    servo = 8'd150;
                    enter(PH_SWEEP_RIGHT, 25);
                end
                default: begin
                    right_cm = last_cm;
                    servo = 8'd30;
                    enter(PH_SWEEP_CENTRE, 25);
                end
            endcase
        end

        r = '0;
        r.servo_angle = servo;
        case (motion)
            MODE_FWD: begin
                r.left_direction = DIR_FWD;
                r.right_direction = DIR_FWD;
            end
            MODE_BACK: begin
                r.left_direction = DIR_BACK;
                r.right_direction = DIR_BACK;
            end
            MODE_LEFT: begin
                r.left_direction = DIR_FWD;
                r.right_direction = DIR_BACK;
            end
            MODE_RIGHT: begin
                r.left_direction = DIR_BACK;
                r.right_direction = DIR_FWD;
            end
            default: begin
                r.left_direction = DIR_OFF;
                r.right_direction = DIR_OFF;
            end
        endcase
        r.left_duty = motion_duty;
        r.right_duty = motion_duty;
        r.measure_request = measuring();
        r.distance_cm = last_cm;
        if (motion != MODE_STOP) r.action = motion;
        else if (phase <= PH_CENTRE_WAIT && phase != PH_STOP_WAIT) r.action = ACT_SCAN;
        else r.action = ACT_STOPPED;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            fwd_duty = 8'd180;
            spin_duty = 8'd200;
            obstacle_cm = 10'd20;
            phase = PH_FRONT_WAIT;
            ms_left = 250;
            servo = 8'd90;
            left_cm = '0;
            right_cm = '0;
            last_cm = '0;
            drive(MODE_STOP, 8'd0);
            commands_due.delete();
            fail_count = 0;
            word_no = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_FORWARD_DUTY: fwd_duty = cfg_wdata[7:0];
                    REG_TURN_DUTY: spin_duty = cfg_wdata[7:0];
                    REG_OBSTACLE_CM: obstacle_cm = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                commands_due.push_back(step_sequencer(s_tuser, s_tdata[14:0]));
            if (m_tvalid && m_tready) begin
                word_no++;
                got = result_t'(m_tdata[41:0]);
                if (commands_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Result word %0d arrived with nothing expected: %h",
                                 word_no, m_tdata);
                end else begin
                    want = commands_due.pop_front();
                    if (got.servo_angle != want.servo_angle
                            || got.left_direction != want.left_direction
                            || got.right_direction != want.right_direction
                            || got.left_duty != want.left_duty
                            || got.right_duty != want.right_duty
                            || got.measure_request != want.measure_request
                            || got.distance_cm != want.distance_cm
                            || got.action != want.action
                            || m_tdata[47:42] != '0) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("Result word %0d differs.", word_no);
                            $display("  expected servo %0d dir %0d/%0d duty %0d/%0d req %0d dist %0d act %0d",
                                     want.servo_angle, want.left_direction,
                                     want.right_direction, want.left_duty, want.right_duty,
                                     want.measure_request, want.distance_cm, want.action);
                            $display("  actual   servo %0d dir %0d/%0d duty %0d/%0d req %0d dist %0d act %0d pad %h",
                                     got.servo_angle, got.left_direction,
                                     got.right_direction, got.left_duty, got.right_duty,
                                     got.measure_request, got.distance_cm, got.action,
                                     m_tdata[47:42]);
                        end
                    end
                end
            end
        end
        failures <= fail_count;
        pending <= commands_due.size();
    end

endmodule

@@ tb/obstacle_avoidance_sequencer_test.sv @@
// Testbench top for the obstacle avoidance sequencer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module obstacle_avoidance_sequencer_test;
    import oas_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [9:0]  cfg_wdata;
    int          failures;
    int          pending;

    logic [9:0]  obstacle_setting;
    logic [14:0] last_echo;
    bit          sender_quiet;

    obstacle_avoidance_sequencer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    oas_result_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .failures  (failures),
        .pending   (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #100_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_word(input logic op, input logic [14:0] us);
        int r;
        int gap;
        gap = 0;
        if (!sender_quiet) begin
            r = $urandom_range(0, 99);
            if (r >= 92) gap = $urandom_range(8, 30);
            else if (r >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {1'b0, us};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        for (int n = 0; n < 5000 && pending != 0; n++) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_config(input logic [9:0] fwd, input logic [9:0] turn,
                                input logic [9:0] obs);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= REG_FORWARD_DUTY;
        cfg_wdata <= fwd;
        @(posedge aclk);
        cfg_index <= REG_TURN_DUTY;
        cfg_wdata <= turn;
        @(posedge aclk);
        cfg_index <= REG_OBSTACLE_CM;
        cfg_wdata <= obs;
        @(posedge aclk);
        cfg_index <= REG_UNUSED;
        cfg_wdata <= 10'($urandom_range(0, 1023));
        @(posedge aclk);
        cfg_we <= 1'b0;
        obstacle_setting = obs;
    endtask

    // Echo widths are biased towards no echo, time-outs, the blocking threshold and
    // repeats of the previous width, so that equal side clearances also occur.
    function automatic logic [14:0] pick_echo();
        int r;
        int us;
        r = $urandom_range(0, 99);
        if (r < 12) us = 0;
        else if (r < 22) us = $urandom_range(30001, 32767);
        else if (r < 47) us = int'(obstacle_setting) * 1000 / 17
                              + int'($urandom_range(0, 120)) - 60;
        else if (r < 62) us = last_echo;
        else if (r < 77) us = $urandom_range(1, 1200);
        else us = $urandom_range(1, 30000);
        if (us < 0) us = 0;
        if (us > 32767) us = 32767;
        last_echo = us[14:0];
        return last_echo;
    endfunction

    initial begin : receiver
        int cycle_no;
        int stall_left;
        bit rx_quiet;
        cycle_no = 0;
        stall_left = 0;
        rx_quiet = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            cycle_no++;
            if (cycle_no % 500 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
            if (cycle_no % 1500 == 600) begin
                stall_left = 400;
            end else if (stall_left == 0 && !rx_quiet && $urandom_range(0, 5) == 0) begin
                if ($urandom_range(0, 99) < 85) stall_left = $urandom_range(1, 3);
                else stall_left = $urandom_range(8, 30);
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = OP_TICK;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = REG_FORWARD_DUTY;
        cfg_wdata = '0;
        obstacle_setting = 10'd20;
        last_echo = '0;
        sender_quiet = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Echoes outside a measurement are ignored; ticks while measuring are ignored.
        send_word(OP_ECHO, 15'd0);
        send_word(OP_ECHO, 15'h7FFF);
        send_word(OP_TICK, 15'h7FFF);
        send_word(OP_TICK, 15'd0);
        repeat (248) send_word(OP_TICK, 15'($urandom_range(0, 32767)));
        send_word(OP_TICK, 15'h7FFF);
        send_word(OP_TICK, 15'd0);
        send_word(OP_ECHO, 15'd30000);
        repeat (350) send_word(OP_TICK, 15'($urandom_range(0, 32767)));
        send_word(OP_ECHO, 15'd30001);
        repeat (350) send_word(OP_TICK, 15'($urandom_range(0, 32767)));
        send_word(OP_ECHO, 15'd1);

        for (int setting = 0; setting < 6; setting++) begin
            case (setting)
                1: write_config(10'd0, 10'd255, 10'd999);
                2: write_config(10'h3FF, 10'd0, 10'd0);
                3: write_config(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                                10'($urandom_range(20, 300)));
                4: write_config(10'd1, 10'd128, 10'h3FF);
                5: write_config(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                                10'($urandom_range(0, 1023)));
                default: ;
            endcase
            for (int n = 0; n < 25; n++) begin
                if (n % 10 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 11) == 0) send_word(OP_ECHO, pick_echo());
                else send_word(OP_TICK, 15'($urandom_range(0, 32767)));
            end
        end

        drain();
        if (failures == 0 && pending == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ obstacle_avoidance_sequencer.f @@
hdl/oas_pkg.sv
hdl/oas_in_stage.sv
hdl/oas_core.sv
hdl/obstacle_avoidance_sequencer.sv
tb/oas_result_checker.sv
tb/obstacle_avoidance_sequencer_test.sv
